// ===== rtl/core/hmcs_pkg.sv =====
// ---------------------------------------------------------------------------
// hmcs_pkg
// Types, character codes and match helpers for the meta charset scanner.
// ---------------------------------------------------------------------------
`default_nettype none

package hmcs_pkg;

  localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
  localparam logic [7:0] CH_EQ     = 8'h3D;  // '='
  localparam logic [7:0] CH_DASH   = 8'h2D;  // '-'
  localparam logic [7:0] CH_SPACE  = 8'h20;  // ' '
  localparam logic [7:0] CH_SQUOTE = 8'h27;  // '\''
  localparam logic [7:0] CH_DQUOTE = 8'h22;  // '"'
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
  localparam logic [7:0] CH_M      = 8'h6D;  // 'm'
  localparam logic [7:0] CH_C      = 8'h63;  // 'c'

  localparam logic [2:0] META_LEN    = 3'd4;
  localparam logic [2:0] CHARSET_LEN = 3'd7;

  typedef enum logic [3:0] {
    PH_SEEK_LT  = 4'd0,
    PH_AFTER_LT = 4'd1,
    PH_META     = 4'd2,
    PH_IN_TAG   = 4'd3,
    PH_SEEK_EQ  = 4'd4,
    PH_AFTER_EQ = 4'd5,
    PH_SQUOTE   = 4'd6,
    PH_DQUOTE   = 4'd7,
    PH_BARE     = 4'd8,
    PH_DONE     = 4'd9
  } phase_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       end_of_document;
  } hmcs_item_t;

  typedef struct packed {
    logic [7:0] value_char;
    logic       has_char;
    logic       value_done;
  } hmcs_result_t;

  // lower-case letter, or zero for anything that is not a letter
  function automatic logic [7:0] fold_lc(input logic [7:0] b);
    logic is_letter;
    is_letter = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    return is_letter ? (b | 8'h20) : 8'h00;
  endfunction

  function automatic logic is_token(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           ((b >= 8'h30) && (b <= 8'h39)) || (b == CH_DASH);
  endfunction

  function automatic logic [7:0] meta_letter(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h6D;  // m
      3'd1:    c = 8'h65;  // e
      3'd2:    c = 8'h74;  // t
      3'd3:    c = 8'h61;  // a
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] charset_letter(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h63;  // c
      3'd1:    c = 8'h68;  // h
      3'd2:    c = 8'h61;  // a
      3'd3:    c = 8'h72;  // r
      3'd4:    c = 8'h73;  // s
      3'd5:    c = 8'h65;  // e
      3'd6:    c = 8'h74;  // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hmcs_in_stage.sv =====
// ---------------------------------------------------------------------------
// hmcs_in_stage
// Input register: holds one accepted byte until the scanner consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module hmcs_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hmcs_pkg::hmcs_item_t in_item,
  input  wire logic               advance,
  output logic                    item_valid,
  output hmcs_pkg::hmcs_item_t    item
);
  import hmcs_pkg::*;

  logic       valid_r;
  hmcs_item_t item_r;

  // take a new byte when the register is empty or the held one leaves in the same cycle
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hmcs_scan_fsm.sv =====
// ---------------------------------------------------------------------------
// hmcs_scan_fsm
// Tag / keyword / value state machine, one byte per step.
// ---------------------------------------------------------------------------
`default_nettype none

module hmcs_scan_fsm (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire hmcs_pkg::hmcs_item_t item,
  output hmcs_pkg::hmcs_result_t    res,
  output logic                      res_valid
);
  import hmcs_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [2:0] prog_r, prog_nxt;

  logic [7:0] b;
  logic [7:0] lc;
  logic       eod;
  logic       open_value;

  assign b   = item.body_byte;
  assign eod = item.end_of_document;
  assign lc  = fold_lc(b);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    prog_nxt  = prog_r;
    case (phase_r)
      PH_AFTER_LT: begin
        if (b == CH_SPACE) begin
          phase_nxt = PH_AFTER_LT;
        end else if (lc == CH_M) begin
          phase_nxt = PH_META;
          prog_nxt  = 3'd1;
        end else begin
          phase_nxt = PH_SEEK_LT;
        end
      end
      PH_META: begin
        if ((prog_r >= 3'd1) && (prog_r < META_LEN) && (lc == meta_letter(prog_r))) begin
          if (prog_r + 3'd1 == META_LEN) begin
            phase_nxt = PH_IN_TAG;
            prog_nxt  = 3'd0;
          end else begin
            prog_nxt = prog_r + 3'd1;
          end
        end else begin
          prog_nxt  = 3'd0;
          phase_nxt = (b == CH_LT) ? PH_AFTER_LT : PH_SEEK_LT;
        end
      end
      PH_IN_TAG: begin
        if ((prog_r < CHARSET_LEN) && (lc == charset_letter(prog_r))) begin
          if (prog_r + 3'd1 == CHARSET_LEN) begin
            phase_nxt = PH_SEEK_EQ;
            prog_nxt  = 3'd0;
          end else begin
            prog_nxt = prog_r + 3'd1;
          end
        end else begin
          // failing byte is looked at again from the start of the word
          prog_nxt = 3'd0;
          if (b == CH_GT) begin
            phase_nxt = PH_SEEK_LT;
          end else if (lc == CH_C) begin
            prog_nxt = 3'd1;
          end
        end
      end
      PH_SEEK_EQ: begin
        if (b == CH_EQ) begin
          phase_nxt = PH_AFTER_EQ;
        end
      end
      PH_AFTER_EQ: begin
        if (b == CH_SPACE) begin
          phase_nxt = PH_AFTER_EQ;
        end else if (b == CH_SQUOTE) begin
          phase_nxt = PH_SQUOTE;
        end else if (b == CH_DQUOTE) begin
          phase_nxt = PH_DQUOTE;
        end else if (is_token(b)) begin
          phase_nxt = PH_BARE;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_SQUOTE: begin
        if (b == CH_SQUOTE) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DQUOTE: begin
        if (b == CH_DQUOTE) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_BARE: begin
        if (!is_token(b)) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        // searching for '<'
        prog_nxt  = 3'd0;
        phase_nxt = (b == CH_LT) ? PH_AFTER_LT : PH_SEEK_LT;
      end
    endcase
    if (eod) begin
      phase_nxt = PH_SEEK_LT;
      prog_nxt  = 3'd0;
    end
  end

  // outputs
  always_comb begin
    res.value_char = 8'h00;
    res.has_char   = 1'b0;
    res.value_done = 1'b0;
    case (phase_r)
      PH_AFTER_EQ: begin
        if ((b == CH_SPACE) || (b == CH_SQUOTE) || (b == CH_DQUOTE)) begin
          res.has_char = 1'b0;
        end else if (is_token(b)) begin
          res.value_char = b;
          res.has_char   = 1'b1;
        end else begin
          res.value_done = 1'b1;
        end
      end
      PH_SQUOTE: begin
        if (b == CH_SQUOTE) begin
          res.value_done = 1'b1;
        end else begin
          res.value_char = b;
          res.has_char   = 1'b1;
        end
      end
      PH_DQUOTE: begin
        if (b == CH_DQUOTE) begin
          res.value_done = 1'b1;
        end else begin
          res.value_char = b;
          res.has_char   = 1'b1;
        end
      end
      PH_BARE: begin
        if (is_token(b)) begin
          res.value_char = b;
          res.has_char   = 1'b1;
        end else begin
          res.value_done = 1'b1;
        end
      end
      default: begin
        res.has_char = 1'b0;
      end
    endcase
    // document end closes a value that is still open after this byte
    open_value = (phase_nxt == PH_AFTER_EQ) || (phase_nxt == PH_SQUOTE) ||
                 (phase_nxt == PH_DQUOTE) || (phase_nxt == PH_BARE);
    if (eod) begin
      open_value = ((phase_r == PH_SEEK_EQ) && (b == CH_EQ)) ||
                   (phase_r == PH_AFTER_EQ) || (phase_r == PH_BARE && is_token(b)) ||
                   (phase_r == PH_SQUOTE && b != CH_SQUOTE) ||
                   (phase_r == PH_DQUOTE && b != CH_DQUOTE);
      if (open_value) begin
        res.value_done = 1'b1;
      end
    end
    res_valid = res.has_char || res.value_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK_LT;
      prog_r  <= 3'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      prog_r  <= prog_nxt;
    end
  end

  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.value_done) |=> (phase_r == PH_DONE) || (phase_r == PH_SEEK_LT))
    else $error("value end without leaving the value phases");

  a_quiet_after_value: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> !res_valid)
    else $error("result after the value was complete");

  a_eod_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.end_of_document) |=> (phase_r == PH_SEEK_LT) && (prog_r == 3'd0))
    else $error("state not cleared at document end");

  a_char_in_value: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.has_char) |-> (phase_r == PH_AFTER_EQ) || (phase_r == PH_SQUOTE) ||
                               (phase_r == PH_DQUOTE) || (phase_r == PH_BARE))
    else $error("value byte outside a value");

endmodule

`default_nettype wire

// ===== rtl/core/hmcs_out_stage.sv =====
// ---------------------------------------------------------------------------
// hmcs_out_stage
// Result register: holds one result until the consumer takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module hmcs_out_stage (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load,
  input  wire hmcs_pkg::hmcs_result_t res,
  output logic                        free,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output hmcs_pkg::hmcs_result_t      out_res
);
  import hmcs_pkg::*;

  logic         valid_r;
  hmcs_result_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/html_meta_charset_scanner.sv =====
// ---------------------------------------------------------------------------
// html_meta_charset_scanner
// Finds the charset value of the first meta tag with a charset attribute in an HTML byte stream.
// ---------------------------------------------------------------------------
// Accepts one document byte per clock and returns the bytes of the charset
// value of the first <meta ... charset=...> tag, then a value_done mark
// (which may come alone, as for an empty value or at a closing quote, or
// with the last byte when that byte ends the document). A byte flagged
// end_of_document clears the scanner for the next document. An accepted
// byte is held in the input register, and its result is loaded into the
// result register once that register is free, which raises out_valid.
// Throughput is one byte per cycle while the result register stays free,
// set by the state update of the scanner state machine. Bytes that produce
// no result are dropped internally. Backpressure on out_ready stalls intake
// only once both registers are occupied.
`default_nettype none

module html_meta_charset_scanner (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_body_byte,
  input  wire logic       in_end_of_document,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_value_char,
  output logic            out_has_char,
  output logic            out_value_done
);
  import hmcs_pkg::*;

  hmcs_item_t   in_item;
  hmcs_item_t   item;
  logic         item_valid;
  logic         advance;
  logic         out_free;
  hmcs_result_t res;
  logic         res_valid;
  hmcs_result_t out_res;

  assign in_item.body_byte       = in_body_byte;
  assign in_item.end_of_document = in_end_of_document;

  assign advance = item_valid && out_free;

  hmcs_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  hmcs_scan_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (item),
    .res       (res),
    .res_valid (res_valid)
  );

  hmcs_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_value_char = out_res.value_char;
  assign out_has_char   = out_res.has_char;
  assign out_value_done = out_res.value_done;

endmodule

`default_nettype wire
